/* hw/rtl/rot3d_pkg.sv */
`timescale 1ns / 1ps

package rot3d_pkg;

   // Coordinate and CORDIC sizing
   localparam int COORD_WIDTH   = 32;
   localparam int CORDIC_STAGES = 16;
   localparam int BAM_W         = 32;  // binary angle, full turn = 2^32
   localparam int CORDIC_W      = 32;  // Q30 cosine / sine datapath

   localparam int COEF_FRAC = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
   localparam int COEF_SH   = 30 - COEF_FRAC;
   localparam int COEF_W    = COEF_FRAC + 2;
   localparam int PROD_W    = COORD_WIDTH + COEF_W;
   localparam int ACC_W     = PROD_W + 1;

   // Angle reduction: 360 degrees in 1/256 degree units
   localparam int ANG_W     = 20;
   localparam int ANG_FULL  = 92160;
   localparam int ANG_TURNS = 12;
   localparam int ANG_OFF   = (ANG_TURNS / 2) * ANG_FULL;
   localparam int VW        = $clog2(ANG_TURNS * ANG_FULL);
   localparam int RW        = $clog2(ANG_FULL);
   // ANG_FULL = ANG_DIV * 2^QW
   localparam int ANG_DIV   = 45;
   localparam int QW        = 11;
   localparam int FRAC_W    = BAM_W - QW;
   localparam int MW        = $clog2(ANG_DIV);
   localparam int RECIP_W   = 18;
   localparam int RECIP_SH  = 23;
   localparam logic [RECIP_W-1:0] RECIP_DIV = 18'd186414;  // ceil(2^23 / 45)

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [BAM_W-1:0] QUARTER_TURN = 32'sd1073741824;

   typedef enum logic [1:0] {
      AXIS_X    = 2'b00,
      AXIS_Y    = 2'b01,
      AXIS_Z    = 2'b10,
      AXIS_NONE = 2'b11
   } axis_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      vec_type  v;
      axis_type axis;
   } pnt_type;

   // Arctangent of 2^-i in binary angle units
   localparam logic signed [BAM_W-1:0] ATAN_TURN [32] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1,         32'sd1,         32'sd0
   };

   // floor((m * 2^21 + 22) / 45): low binary angle bits for remainder m
   localparam logic [FRAC_W-1:0] FRAC_TAB [ANG_DIV] = '{
      21'd0,       21'd46603,   21'd93207,   21'd139810,  21'd186414,
      21'd233017,  21'd279620,  21'd326224,  21'd372827,  21'd419430,
      21'd466034,  21'd512637,  21'd559241,  21'd605844,  21'd652447,
      21'd699051,  21'd745654,  21'd792257,  21'd838861,  21'd885464,
      21'd932068,  21'd978671,  21'd1025274, 21'd1071878, 21'd1118481,
      21'd1165084, 21'd1211688, 21'd1258291, 21'd1304895, 21'd1351498,
      21'd1398101, 21'd1444705, 21'd1491308, 21'd1537911, 21'd1584515,
      21'd1631118, 21'd1677722, 21'd1724325, 21'd1770928, 21'd1817532,
      21'd1864135, 21'd1910738, 21'd1957342, 21'd2003945, 21'd2050549
   };

endpackage

/* hw/rtl/rot3d_angle.sv */
`timescale 1ns / 1ps

module rot3d_angle (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [rot3d_pkg::ANG_W-1:0]   in_angle,
   input  rot3d_pkg::pnt_type                   in_pnt,
   output logic                                 out_valid,
   output logic signed [rot3d_pkg::BAM_W-1:0]   out_za,
   output logic                                 out_neg,
   output rot3d_pkg::pnt_type                   out_pnt
);

   localparam int VW  = rot3d_pkg::VW;
   localparam int RW  = rot3d_pkg::RW;
   localparam int QW  = rot3d_pkg::QW;
   localparam int MW  = rot3d_pkg::MW;
   localparam int BW  = rot3d_pkg::BAM_W;
   localparam int PW  = RW + rot3d_pkg::RECIP_W;

   // stage 1: angle mod 360
   logic              vld1_ff;
   logic [RW-1:0]     r1_ff, r1_in;
   rot3d_pkg::pnt_type pnt1_ff;

   // stage 2: quotient by the odd factor of 360 degrees
   logic              vld2_ff;
   logic [RW-1:0]     r2_ff;
   logic [QW-1:0]     q2_ff, q2_in;
   rot3d_pkg::pnt_type pnt2_ff;

   // stage 3: binary angle and quadrant fold
   logic                  vld3_ff;
   logic signed [BW-1:0]  za3_ff, za3_in;
   logic                  neg3_ff, neg3_in;
   rot3d_pkg::pnt_type    pnt3_ff;

   logic signed [VW:0]    vsum;
   logic [VW-1:0]         v;
   logic [VW-1:0]         sub;
   logic [PW-1:0]         prod;
   logic [RW-1:0]         qm;
   logic [MW-1:0]         m;
   logic [BW-1:0]         bam;

   always_comb begin
      vsum = (VW + 1)'(in_angle) + (VW + 1)'(rot3d_pkg::ANG_OFF);
      v    = vsum[VW-1:0];
      sub  = '0;
      for (int k = 1; k < rot3d_pkg::ANG_TURNS; k++) begin
         if (v >= VW'(k * rot3d_pkg::ANG_FULL)) begin
            sub = VW'(k * rot3d_pkg::ANG_FULL);
         end
      end
      r1_in = RW'(v - sub);
   end

   always_comb begin
      prod  = PW'(r1_ff) * PW'(rot3d_pkg::RECIP_DIV);
      q2_in = prod[rot3d_pkg::RECIP_SH +: QW];
   end

   always_comb begin
      qm      = RW'(q2_ff) * RW'(rot3d_pkg::ANG_DIV);
      m       = MW'(r2_ff - qm);
      bam     = {q2_ff, rot3d_pkg::FRAC_TAB[m]};
      neg3_in = ($signed(bam) > rot3d_pkg::QUARTER_TURN) ||
                ($signed(bam) < -rot3d_pkg::QUARTER_TURN);
      // move by half a turn; cosine and sine flip sign later
      za3_in  = neg3_in ? $signed({~bam[BW-1], bam[BW-2:0]}) : $signed(bam);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ff   <= r1_in;
         pnt1_ff <= in_pnt;
         r2_ff   <= r1_ff;
         q2_ff   <= q2_in;
         pnt2_ff <= pnt1_ff;
         za3_ff  <= za3_in;
         neg3_ff <= neg3_in;
         pnt3_ff <= pnt2_ff;
      end
   end

   assign out_valid = vld3_ff;
   assign out_za    = za3_ff;
   assign out_neg   = neg3_ff;
   assign out_pnt   = pnt3_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld2_ff |-> (m < MW'(rot3d_pkg::ANG_DIV)))
      else $error("angle remainder out of range");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> ((za3_ff <= rot3d_pkg::QUARTER_TURN) &&
                   (za3_ff >= -rot3d_pkg::QUARTER_TURN)))
      else $error("folded angle beyond a quarter turn");

endmodule

/* hw/rtl/rot3d_cordic.sv */
`timescale 1ns / 1ps

module rot3d_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic signed [rot3d_pkg::BAM_W-1:0]    in_za,
   input  logic                                  in_neg,
   input  rot3d_pkg::pnt_type                    in_pnt,
   output logic                                  out_valid,
   output logic signed [rot3d_pkg::CORDIC_W-1:0] out_cx,
   output logic signed [rot3d_pkg::CORDIC_W-1:0] out_cy,
   output logic                                  out_neg,
   output rot3d_pkg::pnt_type                    out_pnt
);

   localparam int NS = rot3d_pkg::CORDIC_STAGES;
   localparam int CW = rot3d_pkg::CORDIC_W;
   localparam int BW = rot3d_pkg::BAM_W;

   logic signed [CW-1:0] cx_ff [NS];
   logic signed [CW-1:0] cy_ff [NS];
   logic signed [BW-1:0] za_ff [NS];
   logic signed [CW-1:0] cx_in [NS];
   logic signed [CW-1:0] cy_in [NS];
   logic signed [BW-1:0] za_in [NS];
   logic                 vld_ff [NS];
   logic                 neg_ff [NS];
   rot3d_pkg::pnt_type   pnt_ff [NS];

   // stage inputs: index 0 is the entry, index i+1 is the output of stage i
   logic signed [CW-1:0] cx_st [NS+1];
   logic signed [CW-1:0] cy_st [NS+1];
   logic signed [BW-1:0] za_st [NS+1];
   logic                 vld_st [NS+1];
   logic                 neg_st [NS+1];
   rot3d_pkg::pnt_type   pnt_st [NS+1];

   assign cx_st[0]  = rot3d_pkg::CORDIC_GAIN_Q30;
   assign cy_st[0]  = '0;
   assign za_st[0]  = in_za;
   assign vld_st[0] = in_valid;
   assign neg_st[0] = in_neg;
   assign pnt_st[0] = in_pnt;

   for (genvar i = 0; i < NS; i++) begin : g_stage
      // rotate toward zero residual angle; shifts round toward minus infinity
      assign cx_in[i] = za_st[i][BW-1] ? cx_st[i] + (cy_st[i] >>> i)
                                       : cx_st[i] - (cy_st[i] >>> i);
      assign cy_in[i] = za_st[i][BW-1] ? cy_st[i] - (cx_st[i] >>> i)
                                       : cy_st[i] + (cx_st[i] >>> i);
      assign za_in[i] = za_st[i][BW-1] ? za_st[i] + rot3d_pkg::ATAN_TURN[i]
                                       : za_st[i] - rot3d_pkg::ATAN_TURN[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_st[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            cx_ff[i]  <= cx_in[i];
            cy_ff[i]  <= cy_in[i];
            za_ff[i]  <= za_in[i];
            neg_ff[i] <= neg_st[i];
            pnt_ff[i] <= pnt_st[i];
         end
      end

      assign cx_st[i+1]  = cx_ff[i];
      assign cy_st[i+1]  = cy_ff[i];
      assign za_st[i+1]  = za_ff[i];
      assign vld_st[i+1] = vld_ff[i];
      assign neg_st[i+1] = neg_ff[i];
      assign pnt_st[i+1] = pnt_ff[i];
   end

   assign out_valid = vld_st[NS];
   assign out_cx    = cx_st[NS];
   assign out_cy    = cy_st[NS];
   assign out_neg   = neg_st[NS];
   assign out_pnt   = pnt_st[NS];

endmodule

/* hw/rtl/rot3d_mult.sv */
`timescale 1ns / 1ps

module rot3d_mult (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0] in_cx,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0] in_cy,
   input  logic                                  in_neg,
   input  rot3d_pkg::pnt_type                    in_pnt,
   output logic                                  out_valid,
   output rot3d_pkg::vec_type                    out_vec
);

   localparam int XW  = rot3d_pkg::COORD_WIDTH;
   localparam int KW  = rot3d_pkg::COEF_W;
   localparam int PW  = rot3d_pkg::PROD_W;
   localparam int AW  = rot3d_pkg::ACC_W;
   localparam int NW  = rot3d_pkg::CORDIC_W + 1;
   localparam int FR  = rot3d_pkg::COEF_FRAC;

   localparam logic signed [NW-1:0] COEF_RND = NW'((2 ** rot3d_pkg::COEF_SH) / 2);
   localparam logic signed [AW-1:0] FIN_RND  = AW'(2 ** (FR - 1));
   localparam logic signed [AW-1:0] SAT_HI   = (AW'(1) <<< (XW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] SAT_LO   = -SAT_HI - AW'(1);

   // prep stage: coefficients and operand selection
   logic                  vldp_ff;
   logic signed [KW-1:0]  c_ff, c_in, s_ff, s_in;
   logic signed [XW-1:0]  p_ff, p_in, q_ff, q_in;
   rot3d_pkg::pnt_type    pntp_ff;

   // product stage
   logic                  vldm_ff;
   logic signed [PW-1:0]  cp_ff, sq_ff, sp_ff, cq_ff;
   rot3d_pkg::pnt_type    pntm_ff;

   logic signed [NW-1:0]  cn, sn;
   logic signed [AW-1:0]  accp, accq;
   logic signed [XW-1:0]  outp, outq;

   function automatic logic signed [XW-1:0] finish(input logic signed [AW-1:0] acc);
      logic signed [AW-1:0] t;
      t = (acc + FIN_RND) >>> FR;
      if (t > SAT_HI) begin
         t = SAT_HI;
      end else if (t < SAT_LO) begin
         t = SAT_LO;
      end
      return XW'(t);
   endfunction

   always_comb begin
      cn   = in_neg ? -NW'(in_cx) : NW'(in_cx);
      sn   = in_neg ? -NW'(in_cy) : NW'(in_cy);
      c_in = KW'((cn + COEF_RND) >>> rot3d_pkg::COEF_SH);
      s_in = KW'((sn + COEF_RND) >>> rot3d_pkg::COEF_SH);
      // p' = c*p - s*q, q' = s*p + c*q
      unique case (in_pnt.axis)
         rot3d_pkg::AXIS_X: begin
            p_in = in_pnt.v.y;
            q_in = in_pnt.v.z;
         end
         rot3d_pkg::AXIS_Y: begin
            p_in = in_pnt.v.z;
            q_in = in_pnt.v.x;
         end
         rot3d_pkg::AXIS_Z: begin
            p_in = in_pnt.v.x;
            q_in = in_pnt.v.y;
         end
         default: begin
            p_in = in_pnt.v.x;
            q_in = in_pnt.v.y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldp_ff <= 1'b0;
         vldm_ff <= 1'b0;
      end else if (advance) begin
         vldp_ff <= in_valid;
         vldm_ff <= vldp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff    <= c_in;
         s_ff    <= s_in;
         p_ff    <= p_in;
         q_ff    <= q_in;
         pntp_ff <= in_pnt;
         cp_ff   <= PW'(c_ff) * PW'(p_ff);
         sq_ff   <= PW'(s_ff) * PW'(q_ff);
         sp_ff   <= PW'(s_ff) * PW'(p_ff);
         cq_ff   <= PW'(c_ff) * PW'(q_ff);
         pntm_ff <= pntp_ff;
      end
   end

   always_comb begin
      accp    = AW'(cp_ff) - AW'(sq_ff);
      accq    = AW'(sp_ff) + AW'(cq_ff);
      outp    = finish(accp);
      outq    = finish(accq);
      out_vec = pntm_ff.v;
      unique case (pntm_ff.axis)
         rot3d_pkg::AXIS_X: begin
            out_vec.y = outp;
            out_vec.z = outq;
         end
         rot3d_pkg::AXIS_Y: begin
            out_vec.z = outp;
            out_vec.x = outq;
         end
         rot3d_pkg::AXIS_Z: begin
            out_vec.x = outp;
            out_vec.y = outq;
         end
         default: begin
            out_vec = pntm_ff.v;
         end
      endcase
   end

   assign out_valid = vldm_ff;

endmodule

/* hw/rtl/axis_rotate_3d_vector_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_x_in, req_y_in, req_z_in,
//                                             req_angle_deg, req_axis_sel
// rsp       out        rsp_valid / rsp_ready  rsp_x_out, rsp_y_out, rsp_z_out
//
// One item per cycle while the skid register is empty. Stages in order:
// three angle-reduction stages, one CORDIC stage per iteration, coefficient
// prep, product stage, output register.
// Reset clears every valid bit; no memory to sweep.
// A stalled result moves one following item into a skid register; req_ready drops
// only while that register is full, and the whole pipeline then holds.

module axis_rotate_3d_vector_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [rot3d_pkg::COORD_WIDTH-1:0]  req_x_in,
   input  logic signed [rot3d_pkg::COORD_WIDTH-1:0]  req_y_in,
   input  logic signed [rot3d_pkg::COORD_WIDTH-1:0]  req_z_in,
   input  logic signed [rot3d_pkg::ANG_W-1:0]        req_angle_deg,
   input  logic [1:0]                                req_axis_sel,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [rot3d_pkg::COORD_WIDTH-1:0]  rsp_x_out,
   output logic signed [rot3d_pkg::COORD_WIDTH-1:0]  rsp_y_out,
   output logic signed [rot3d_pkg::COORD_WIDTH-1:0]  rsp_z_out
);

   logic                                      advance;
   rot3d_pkg::pnt_type                        req_pnt;

   logic                                      ang_valid;
   logic signed [rot3d_pkg::BAM_W-1:0]        ang_za;
   logic                                      ang_neg;
   rot3d_pkg::pnt_type                        ang_pnt;

   logic                                      cor_valid;
   logic signed [rot3d_pkg::CORDIC_W-1:0]     cor_cx;
   logic signed [rot3d_pkg::CORDIC_W-1:0]     cor_cy;
   logic                                      cor_neg;
   rot3d_pkg::pnt_type                        cor_pnt;

   logic                                      mul_valid;
   rot3d_pkg::vec_type                        mul_vec;

   logic                                      rsp_valid_ff, rsp_valid_in;
   logic                                      skid_valid_ff, skid_valid_in;
   rot3d_pkg::vec_type                        rsp_vec_ff, skid_vec_ff;
   logic                                      out_free;
   logic                                      load_rsp_skid, load_rsp_pipe, load_skid;

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   assign req_pnt.v.x  = req_x_in;
   assign req_pnt.v.y  = req_y_in;
   assign req_pnt.v.z  = req_z_in;
   assign req_pnt.axis = rot3d_pkg::axis_type'(req_axis_sel);

   rot3d_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_angle  (req_angle_deg),
      .in_pnt    (req_pnt),
      .out_valid (ang_valid),
      .out_za    (ang_za),
      .out_neg   (ang_neg),
      .out_pnt   (ang_pnt)
   );

   rot3d_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (ang_valid),
      .in_za     (ang_za),
      .in_neg    (ang_neg),
      .in_pnt    (ang_pnt),
      .out_valid (cor_valid),
      .out_cx    (cor_cx),
      .out_cy    (cor_cy),
      .out_neg   (cor_neg),
      .out_pnt   (cor_pnt)
   );

   rot3d_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (cor_valid),
      .in_cx     (cor_cx),
      .in_cy     (cor_cy),
      .in_neg    (cor_neg),
      .in_pnt    (cor_pnt),
      .out_valid (mul_valid),
      .out_vec   (mul_vec)
   );

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_rsp_skid = 1'b0;
      load_rsp_pipe = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         // drain skid first; pipeline is held meanwhile
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            load_rsp_skid = 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_in  = mul_valid;
         load_rsp_pipe = mul_valid;
      end else if (mul_valid) begin
         skid_valid_in = 1'b1;
         load_skid     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp_skid) begin
         rsp_vec_ff <= skid_vec_ff;
      end else if (load_rsp_pipe) begin
         rsp_vec_ff <= mul_vec;
      end
      if (load_skid) begin
         skid_vec_ff <= mul_vec;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = rsp_vec_ff.x;
   assign rsp_y_out = rsp_vec_ff.y;
   assign rsp_z_out = rsp_vec_ff.z;

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && mul_valid && !skid_valid_ff) |=> skid_valid_ff)
      else $error("stalled item not captured in skid register");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid register did not drain into output");

   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

endmodule
